@@ src/rgbhsl_pkg.sv @@
// Shared types, constants and divider step functions for the RGBC to HSL converter.
// Depends on nothing; the converter top and rgbhsl_finish import it.
`default_nettype none

package rgbhsl_pkg;

  // Scale factors and hue offsets of the integer HSL formulas.
  localparam int PCT_SCALE  = 100;
  localparam int PCT_FULL   = 100;
  localparam int HUE_SCALE  = 60;
  localparam int HUE_FULL   = 360;
  localparam int HUE_GREEN  = 120;
  localparam int HUE_BLUE   = 240;
  localparam int SUM_FULL   = 200;
  localparam int LIT_HALF   = 50;

  // Which channel holds the maximum; red wins ties, then green.
  typedef enum logic [1:0] {
    SEL_R,
    SEL_G,
    SEL_B
  } sel_t;

  // Normalizing divider stage: channel * 100 / clear, bit 7 flags overflow.
  typedef struct packed {
    logic             inv;
    logic [15:0]      clr;
    logic [2:0][22:0] rem;
    logic [2:0][7:0]  q;
  } divp_t;

  // Percentages reduced to max, min and the two operands of the hue difference.
  typedef struct packed {
    logic       inv;
    sel_t       sel;
    logic [6:0] mx;
    logic [6:0] mn;
    logic [6:0] opa;
    logic [6:0] opb;
  } mm_t;

  // Hue and saturation divider stage.
  typedef struct packed {
    logic        inv;
    logic        flat;
    logic        neg;
    sel_t        sel;
    logic [6:0]  lit;
    logic [13:0] hrem;
    logic [7:0]  hden;
    logic [6:0]  hq;
    logic [13:0] srem;
    logic [7:0]  sden;
    logic [6:0]  sq;
  } hs_t;

  // One restoring step on the normalizing divider: {quotient bit, remainder}.
  function automatic logic [23:0] pct_step(input logic [22:0] rem, input logic [15:0] d,
                                           input int k);
    logic [22:0] ds;
    ds = 23'(d) << k;
    if (rem >= ds) return {1'b1, rem - ds};
    return {1'b0, rem};
  endfunction

  // One restoring step on the hue and saturation dividers.
  function automatic logic [14:0] hs_step(input logic [13:0] rem, input logic [7:0] d,
                                          input int k);
    logic [13:0] ds;
    ds = 14'(d) << k;
    if (rem >= ds) return {1'b1, rem - ds};
    return {1'b0, rem};
  endfunction

endpackage

`default_nettype wire

@@ src/rgbhsl_if.sv @@
// Valid/ready channel interfaces for the sample request and the result request.
// Depends on nothing.
`default_nettype none

interface rgbc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] red;
  logic [15:0] green;
  logic [15:0] blue;
  logic [15:0] clear;

  modport source (output valid, output red, output green, output blue, output clear,
                  input ready);
  modport sink   (input valid, input red, input green, input blue, input clear,
                  output ready);
endinterface

interface hsl_out_if;
  logic       valid;
  logic       ready;
  logic [8:0] hue;
  logic [6:0] saturation;
  logic [6:0] lightness;
  logic       invalid;

  modport source (output valid, output hue, output saturation, output lightness,
                  output invalid, input ready);
  modport sink   (input valid, input hue, input saturation, input lightness,
                  input invalid, output ready);
endinterface

`default_nettype wire

@@ src/rgbc_to_hsl_converter.sv @@
// Top level of the RGBC to HSL converter: a twelve-stage pipeline of restoring dividers.
// Depends on rgbhsl_pkg, rgbhsl_if and rgbhsl_finish.
`default_nettype none

//  channel  | port    | direction | payload
//  ---------+---------+-----------+--------------------------------------
//  sample   | sample  | in        | red, green, blue, clear (16 bit each)
//  result   | result  | out       | hue, saturation, lightness, invalid
//
// One request enters per cycle while the result side is not stalled. A result passes
// through the pipeline of restoring dividers: four stages of two quotient bits for the
// normalization, then three stages of two bits and one stage of one bit for the parallel
// hue and saturation division, plus the input, min/max, operand and output registers.
// Reset clears the stage valid bits only. Each stage holds while the one after it is
// full and stalled, so a stall on the result side fills bubbles before it backs up.

module rgbc_to_hsl_converter (
  input  logic        clk,
  input  logic        rst,
  rgbc_in_if.sink     sample,
  hsl_out_if.source   result
);
  import rgbhsl_pkg::*;

  localparam int NSTG = 12;

  logic [NSTG-1:0] v;
  logic [NSTG:0]   en;

  divp_t pd [0:4];
  mm_t   mm;
  hs_t   hs [0:4];

  logic [8:0] fin_hue;
  logic [6:0] fin_sat;
  logic [6:0] fin_lit;
  logic [8:0] out_hue;
  logic [6:0] out_sat;
  logic [6:0] out_lit;
  logic       out_inv;

  // A stage loads when it is empty or the stage after it moves on.
  assign en[NSTG] = result.ready;
  for (genvar i = 0; i < NSTG; i++) begin : g_en
    assign en[i] = ~v[i] | en[i+1];
  end
  assign sample.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= sample.valid;
      for (int i = 1; i < NSTG; i++) begin
        if (en[i]) v[i] <= v[i-1];
      end
    end
  end

  // Input stage: scale each channel by 100 ahead of the division by clear.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      pd[0].inv    <= (sample.clear == '0);
      pd[0].clr    <= sample.clear;
      pd[0].rem[0] <= 23'(sample.red) * 23'(PCT_SCALE);
      pd[0].rem[1] <= 23'(sample.green) * 23'(PCT_SCALE);
      pd[0].rem[2] <= 23'(sample.blue) * 23'(PCT_SCALE);
      pd[0].q      <= '0;
    end
  end

  // Normalizing dividers: two quotient bits per stage, bit 7 marks a result above 127.
  for (genvar s = 0; s < 4; s++) begin : g_pdiv
    localparam int K1 = 7 - 2 * s;
    localparam int K0 = 6 - 2 * s;
    divp_t            nxt;
    logic [2:0][23:0] t1;
    logic [2:0][23:0] t0;

    always_comb begin
      nxt = pd[s];
      for (int c = 0; c < 3; c++) begin
        t1[c] = pct_step(pd[s].rem[c], pd[s].clr, K1);
        t0[c] = pct_step(t1[c][22:0], pd[s].clr, K0);
        nxt.q[c][K1] = t1[c][23];
        nxt.q[c][K0] = t0[c][23];
        nxt.rem[c]   = t0[c][22:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en[s+1]) pd[s+1] <= nxt;
    end
  end

  // Clamp the percentages and find max, min and the sector of the maximum.
  logic [2:0][6:0] pct;
  logic [6:0]      mx_c;
  logic [6:0]      mn_c;
  mm_t             mm_next;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      pct[c] = (pd[4].q[c][7] || pd[4].q[c][6:0] > 7'(PCT_FULL)) ? 7'(PCT_FULL)
                                                                 : pd[4].q[c][6:0];
    end
    mx_c = pct[0];
    if (pct[1] > mx_c) mx_c = pct[1];
    if (pct[2] > mx_c) mx_c = pct[2];
    mn_c = pct[0];
    if (pct[1] < mn_c) mn_c = pct[1];
    if (pct[2] < mn_c) mn_c = pct[2];

    mm_next.inv = pd[4].inv;
    mm_next.mx  = mx_c;
    mm_next.mn  = mn_c;
    if (pct[0] == mx_c) begin
      mm_next.sel = SEL_R;
      mm_next.opa = pct[1];
      mm_next.opb = pct[2];
    end else if (pct[1] == mx_c) begin
      mm_next.sel = SEL_G;
      mm_next.opa = pct[2];
      mm_next.opb = pct[0];
    end else begin
      mm_next.sel = SEL_B;
      mm_next.opa = pct[0];
      mm_next.opb = pct[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) mm <= mm_next;
  end

  // Form lightness and the numerators and divisors of hue and saturation.
  logic [6:0] dif;
  logic [7:0] sum;
  logic [6:0] mag;
  hs_t        hs_next;

  always_comb begin
    dif = mm.mx - mm.mn;
    sum = 8'(mm.mx) + 8'(mm.mn);
    mag = (mm.opa < mm.opb) ? mm.opb - mm.opa : mm.opa - mm.opb;

    hs_next.inv  = mm.inv;
    hs_next.flat = (dif == '0);
    hs_next.neg  = (mm.opa < mm.opb);
    hs_next.sel  = mm.sel;
    hs_next.lit  = sum[7:1];
    hs_next.hrem = 14'(mag) * 14'(HUE_SCALE);
    hs_next.hden = 8'(dif);
    hs_next.hq   = '0;
    hs_next.srem = 14'(dif) * 14'(PCT_SCALE);
    hs_next.sden = (sum[7:1] <= 7'(LIT_HALF)) ? sum : 8'(SUM_FULL) - sum;
    hs_next.sq   = '0;
  end

  always_ff @(posedge clk) begin
    if (en[6]) hs[0] <= hs_next;
  end

  // Hue and saturation dividers: two quotient bits per stage, one in the last.
  for (genvar s = 0; s < 4; s++) begin : g_hdiv
    localparam int K1 = 6 - 2 * s;
    localparam int K0 = 5 - 2 * s;
    hs_t         nxt;
    logic [14:0] h1;
    logic [14:0] s1;

    if (K0 >= 0) begin : g_two
      logic [14:0] h0;
      logic [14:0] s0;
      always_comb begin
        nxt = hs[s];
        h1  = hs_step(hs[s].hrem, hs[s].hden, K1);
        h0  = hs_step(h1[13:0], hs[s].hden, K0);
        s1  = hs_step(hs[s].srem, hs[s].sden, K1);
        s0  = hs_step(s1[13:0], hs[s].sden, K0);
        nxt.hq[K1] = h1[14];
        nxt.hq[K0] = h0[14];
        nxt.sq[K1] = s1[14];
        nxt.sq[K0] = s0[14];
        nxt.hrem   = h0[13:0];
        nxt.srem   = s0[13:0];
      end
    end else begin : g_one
      always_comb begin
        nxt = hs[s];
        h1  = hs_step(hs[s].hrem, hs[s].hden, K1);
        s1  = hs_step(hs[s].srem, hs[s].sden, K1);
        nxt.hq[K1] = h1[14];
        nxt.sq[K1] = s1[14];
        nxt.hrem   = h1[13:0];
        nxt.srem   = s1[13:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en[s+7]) hs[s+1] <= nxt;
    end
  end

  rgbhsl_finish u_finish (
    .st         (hs[4]),
    .hue        (fin_hue),
    .saturation (fin_sat),
    .lightness  (fin_lit)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (en[11]) begin
      out_hue <= fin_hue;
      out_sat <= fin_sat;
      out_lit <= fin_lit;
      out_inv <= hs[4].inv;
    end
  end

  assign result.valid      = v[11];
  assign result.hue        = out_hue;
  assign result.saturation = out_sat;
  assign result.lightness  = out_lit;
  assign result.invalid    = out_inv;

  // A zero clear gives an all-zero result.
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.invalid |->
      result.hue == '0 && result.saturation == '0 && result.lightness == '0)
    else $error("invalid result carries nonzero fields");

  // Hue stays below a full turn.
  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.hue < 9'(HUE_FULL))
    else $error("hue out of range");

  // Percentages stay within 100.
  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.saturation <= 7'(PCT_FULL) && result.lightness <= 7'(PCT_FULL))
    else $error("percentage out of range");

endmodule

`default_nettype wire

@@ src/rgbhsl_finish.sv @@
// Final hue assembly and saturation clamp from the last divider stage.
// Depends on rgbhsl_pkg.
`default_nettype none

module rgbhsl_finish (
  input  rgbhsl_pkg::hs_t st,
  output logic [8:0]      hue,
  output logic [6:0]      saturation,
  output logic [6:0]      lightness
);
  import rgbhsl_pkg::*;

  logic [8:0] q9;
  logic [8:0] base;
  logic [8:0] hval;

  // Offset the signed quotient by the sector of the maximum channel.
  always_comb begin
    q9   = 9'(st.hq);
    base = '0;
    hval = '0;
    unique case (st.sel)
      SEL_R: begin
        hval = st.neg ? 9'(HUE_FULL) - q9 : q9;
        if (hval == 9'(HUE_FULL)) hval = '0;
      end
      SEL_G: begin
        base = 9'(HUE_GREEN);
        hval = st.neg ? base - q9 : base + q9;
      end
      SEL_B: begin
        base = 9'(HUE_BLUE);
        hval = st.neg ? base - q9 : base + q9;
      end
      default: hval = '0;
    endcase
  end

  // Grey and zero clear force the angle and saturation to zero.
  always_comb begin
    if (st.inv || st.flat) begin
      hue        = '0;
      saturation = '0;
    end else begin
      hue        = hval;
      saturation = (st.sq > 7'(PCT_FULL)) ? 7'(PCT_FULL) : st.sq;
    end
    lightness = st.inv ? '0 : st.lit;
  end

endmodule

`default_nettype wire
